FILE: hdl/hssi_pkg.sv
`default_nettype none

package hssi_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AdcW     = 12;
  localparam int unsigned DbW      = 8;
  localparam int unsigned PulseW   = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_PRESENT_DB  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FUSE_DB     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ADC_THRESH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PULSE_TICKS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IGNORE_FUSE = 3'd4;

  localparam logic [DbW-1:0]    RST_PRESENT_DB  = 8'd3;
  localparam logic [DbW-1:0]    RST_FUSE_DB     = 8'd3;
  localparam logic [AdcW-1:0]   ADC_FULL        = 12'd4095;
  localparam logic [AdcW-1:0]   ADC_MARGIN      = 12'd8;
  localparam logic [AdcW-1:0]   RST_ADC_THRESH  = ADC_FULL - ADC_MARGIN;
  localparam logic [PulseW-1:0] RST_PULSE_TICKS = 16'd100;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_OFFLINE = 2'd1;
  localparam logic [1:0] REASON_LEFT    = 2'd2;
  localparam logic [1:0] REASON_RIGHT   = 2'd3;

  localparam logic [1:0] SIDE_LEFT  = 2'b01;
  localparam logic [1:0] SIDE_RIGHT = 2'b10;

  typedef struct packed {
    logic            kind;
    logic [3:0]      raw_pins;
    logic            running;
    logic            enable_left;
    logic            enable_right;
    logic [AdcW-1:0] adc_left;
    logic            adc_left_valid;
    logic [AdcW-1:0] adc_right;
    logic            adc_right_valid;
    logic            blow_req_left;
    logic            blow_req_right;
  } in_item_t;

  typedef struct packed {
    logic       present_left;
    logic       present_right;
    logic       fuse_left_ok;
    logic       fuse_right_ok;
    logic       stop;
    logic [1:0] stop_cause;
    logic       enable_left_out;
    logic       enable_right_out;
    logic       heat_off_left;
    logic       heat_off_right;
    logic       blow_drive_left;
    logic       blow_drive_right;
  } out_item_t;

  typedef struct packed {
    logic           stable;
    logic [DbW-1:0] cnt;
  } db_state_t;

  // One debounce step: a differing level must be seen need times in a row (once when need is zero).
  function automatic db_state_t hssi_settle(logic raw, db_state_t cur, logic [DbW-1:0] need);
    db_state_t nxt;
    nxt = cur;
    if (raw != cur.stable) begin
      nxt.cnt = cur.cnt + 8'd1;
      if (nxt.cnt >= need) begin
        nxt.stable = raw;
        nxt.cnt    = '0;
      end
    end else begin
      nxt.cnt = '0;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hssi_if.sv
`default_nettype none

interface hssi_in_if;
  logic                valid;
  logic                ready;
  hssi_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hssi_out_if;
  logic                valid;
  logic                ready;
  hssi_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/heater_shield_safety_interlock_core.sv
// A result is registered and offered in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register is refilled in the same cycle it is
// taken, so input ready is low only while a result waits and the output is stalled.
// Reset (async, active low): registers to their defaults, debounced levels to 1,
// debounce counts to zero, no blow pulse, result register empty.
`default_nettype none

module heater_shield_safety_interlock_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hssi_in_if.sink                            in_i,
  hssi_out_if.source                         out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [hssi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [hssi_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [hssi_pkg::DbW-1:0]    present_db_q;
  logic [hssi_pkg::DbW-1:0]    fuse_db_q;
  logic [hssi_pkg::AdcW-1:0]   adc_thresh_q;
  logic [hssi_pkg::PulseW-1:0] pulse_ticks_q;
  logic                        ignore_fuse_q;

  hssi_pkg::db_state_t db_q [4];
  hssi_pkg::db_state_t db_d [4];
  logic [1:0]                  blow_active_q, blow_active_d;
  logic [hssi_pkg::PulseW-1:0] pulse_rem_q, pulse_rem_d;

  hssi_pkg::out_item_t res_d, res_q;
  logic                out_valid_q;
  logic                accept;

  hssi_pkg::in_item_t it;
  logic       need_l, need_r;
  logic [1:0] req;

  assign it          = in_i.data;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      db_d[k] = db_q[k];
    end
    blow_active_d = blow_active_q;
    pulse_rem_d   = pulse_rem_q;
    need_l        = it.running && it.enable_left;
    need_r        = it.running && it.enable_right;
    req           = (it.blow_req_left ? hssi_pkg::SIDE_LEFT : 2'b00) |
                    (it.blow_req_right ? hssi_pkg::SIDE_RIGHT : 2'b00);

    res_d                  = '0;
    res_d.stop_cause       = hssi_pkg::REASON_NONE;
    res_d.enable_left_out  = it.enable_left;
    res_d.enable_right_out = it.enable_right;

    if (it.kind == hssi_pkg::KIND_SAMPLE) begin
      db_d[0] = hssi_pkg::hssi_settle(it.raw_pins[0], db_q[0], present_db_q);
      db_d[1] = hssi_pkg::hssi_settle(it.raw_pins[1], db_q[1], present_db_q);
      db_d[2] = hssi_pkg::hssi_settle(it.raw_pins[2], db_q[2], fuse_db_q);
      db_d[3] = hssi_pkg::hssi_settle(it.raw_pins[3], db_q[3], fuse_db_q);

      if (!db_d[0].stable) begin
        if (need_l) begin
          res_d.stop       = 1'b1;
          res_d.stop_cause = hssi_pkg::REASON_OFFLINE;
        end
        res_d.enable_left_out = 1'b0;
        res_d.heat_off_left   = 1'b1;
      end
      if (!db_d[1].stable) begin
        if (need_r) begin
          res_d.stop       = 1'b1;
          res_d.stop_cause = hssi_pkg::REASON_OFFLINE;
        end
        res_d.enable_right_out = 1'b0;
        res_d.heat_off_right   = 1'b1;
      end
      if (!ignore_fuse_q) begin
        if (!db_d[2].stable) begin
          res_d.enable_left_out = 1'b0;
          res_d.heat_off_left   = 1'b1;
        end
        if (!db_d[3].stable) begin
          res_d.enable_right_out = 1'b0;
          res_d.heat_off_right   = 1'b1;
        end
      end
      // Protector checks only on a side whose shield reads present both ways.
      if (!res_d.stop && need_l && db_d[0].stable && it.raw_pins[0] &&
          it.adc_left_valid && (it.adc_left >= adc_thresh_q)) begin
        res_d.stop       = 1'b1;
        res_d.stop_cause = hssi_pkg::REASON_LEFT;
      end
      if (!res_d.stop && need_r && db_d[1].stable && it.raw_pins[1] &&
          it.adc_right_valid && (it.adc_right >= adc_thresh_q)) begin
        res_d.stop       = 1'b1;
        res_d.stop_cause = hssi_pkg::REASON_RIGHT;
      end
    end else begin
      if (req != 2'b00) begin
        blow_active_d = blow_active_q | req;
        pulse_rem_d   = pulse_ticks_q;
      end else if ((blow_active_q != 2'b00) && (pulse_rem_q != '0)) begin
        pulse_rem_d = pulse_rem_q - 16'd1;
      end
      if ((blow_active_d != 2'b00) && (pulse_rem_d == '0)) begin
        blow_active_d = 2'b00;
      end
    end

    res_d.present_left     = db_d[0].stable;
    res_d.present_right    = db_d[1].stable;
    res_d.fuse_left_ok     = db_d[2].stable;
    res_d.fuse_right_ok    = db_d[3].stable;
    res_d.blow_drive_left  = blow_active_d[0];
    res_d.blow_drive_right = blow_active_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_db_q  <= hssi_pkg::RST_PRESENT_DB;
      fuse_db_q     <= hssi_pkg::RST_FUSE_DB;
      adc_thresh_q  <= hssi_pkg::RST_ADC_THRESH;
      pulse_ticks_q <= hssi_pkg::RST_PULSE_TICKS;
      ignore_fuse_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hssi_pkg::REG_PRESENT_DB:  present_db_q  <= cfg_data_i[hssi_pkg::DbW-1:0];
        hssi_pkg::REG_FUSE_DB:     fuse_db_q     <= cfg_data_i[hssi_pkg::DbW-1:0];
        hssi_pkg::REG_ADC_THRESH:  adc_thresh_q  <= cfg_data_i[hssi_pkg::AdcW-1:0];
        hssi_pkg::REG_PULSE_TICKS: pulse_ticks_q <= cfg_data_i;
        hssi_pkg::REG_IGNORE_FUSE: ignore_fuse_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        db_q[k] <= '{stable: 1'b1, cnt: '0};
      end
      blow_active_q <= 2'b00;
      pulse_rem_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        for (int k = 0; k < 4; k++) begin
          db_q[k] <= db_d[k];
        end
        blow_active_q <= blow_active_d;
        pulse_rem_q   <= pulse_rem_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hssi_checker.sv
`default_nettype none

module hssi_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire hssi_pkg::in_item_t  in_data_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire hssi_pkg::out_item_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // An empty result register never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // Every accepted item produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("accepted item gave no result");

  // A stop always carries a reason, and a reason always means a stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.stop == (out_data_i.stop_cause != hssi_pkg::REASON_NONE)))
    else $error("stop and stop reason disagree");

  // A tick item never stops treatment and passes the enables through.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.kind == hssi_pkg::KIND_TICK) |=>
      !out_data_i.stop && !out_data_i.heat_off_left && !out_data_i.heat_off_right &&
      (out_data_i.enable_left_out == $past(in_data_i.enable_left)) &&
      (out_data_i.enable_right_out == $past(in_data_i.enable_right)))
    else $error("tick item changed the interlock outputs");

endmodule

bind heater_shield_safety_interlock_core hssi_checker u_hssi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

FILE: tb/sv/heater_shield_safety_interlock_core_test.sv
`timescale 1ns / 1ps

module heater_shield_safety_interlock_core_test;

  localparam int IdleLimit = 1000;
  localparam int PhaseItems = 200;

  typedef enum int {RX_OPEN, RX_HOLD, RX_RANDOM} rx_mode_e;

  // Tracks the interlock state and holds the results still owed by the block.
  class interlock_checker;
    logic [hssi_pkg::DbW-1:0]    present_need;
    logic [hssi_pkg::DbW-1:0]    fuse_need;
    logic [hssi_pkg::AdcW-1:0]   adc_thresh;
    logic [hssi_pkg::PulseW-1:0] pulse_len;
    logic                        fuse_ignored;

    logic                        st_pl, st_pr, st_fl, st_fr;
    logic [hssi_pkg::DbW-1:0]    db_cnt [4];
    logic [1:0]                  blow_act;
    logic [hssi_pkg::PulseW-1:0] pulse_left;

    hssi_pkg::out_item_t         awaited_results [$];
    int unsigned                 mismatches;

    function new();
      present_need = hssi_pkg::RST_PRESENT_DB;
      fuse_need    = hssi_pkg::RST_FUSE_DB;
      adc_thresh   = hssi_pkg::RST_ADC_THRESH;
      pulse_len    = hssi_pkg::RST_PULSE_TICKS;
      fuse_ignored = 1'b0;
      st_pl = 1'b1;
      st_pr = 1'b1;
      st_fl = 1'b1;
      st_fr = 1'b1;
      foreach (db_cnt[i]) db_cnt[i] = '0;
      blow_act   = '0;
      pulse_left = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [hssi_pkg::CfgIdxW-1:0] idx,
                          logic [hssi_pkg::CfgDataW-1:0] val);
      case (idx)
        hssi_pkg::REG_PRESENT_DB:  present_need = val[hssi_pkg::DbW-1:0];
        hssi_pkg::REG_FUSE_DB:     fuse_need    = val[hssi_pkg::DbW-1:0];
        hssi_pkg::REG_ADC_THRESH:  adc_thresh   = val[hssi_pkg::AdcW-1:0];
        hssi_pkg::REG_PULSE_TICKS: pulse_len    = val[hssi_pkg::PulseW-1:0];
        hssi_pkg::REG_IGNORE_FUSE: fuse_ignored = val[0];
        default: ;
      endcase
    endfunction

    function void debounce(input logic raw, inout logic stable,
                           inout logic [hssi_pkg::DbW-1:0] cnt,
                           input logic [hssi_pkg::DbW-1:0] need);
      if (raw != stable) begin
        cnt = cnt + 8'd1;
        if (cnt >= need) begin
          stable = raw;
          cnt    = '0;
        end
      end else begin
        cnt = '0;
      end
    endfunction

    function void take_item(hssi_pkg::in_item_t it);
      hssi_pkg::out_item_t exp;
      logic      need_l, need_r;
      logic [1:0] req;
      exp = '0;
      exp.stop_cause       = hssi_pkg::REASON_NONE;
      exp.enable_left_out  = it.enable_left;
      exp.enable_right_out = it.enable_right;
      if (it.kind == hssi_pkg::KIND_SAMPLE) begin
        debounce(it.raw_pins[0], st_pl, db_cnt[0], present_need);
        debounce(it.raw_pins[1], st_pr, db_cnt[1], present_need);
        debounce(it.raw_pins[2], st_fl, db_cnt[2], fuse_need);
        debounce(it.raw_pins[3], st_fr, db_cnt[3], fuse_need);
        need_l = it.running & it.enable_left;
        need_r = it.running & it.enable_right;
        if (!st_pl) begin
          if (need_l) begin
            exp.stop       = 1'b1;
            exp.stop_cause = hssi_pkg::REASON_OFFLINE;
          end
          exp.enable_left_out = 1'b0;
          exp.heat_off_left   = 1'b1;
        end
        if (!st_pr) begin
          if (need_r) begin
            exp.stop       = 1'b1;
            exp.stop_cause = hssi_pkg::REASON_OFFLINE;
          end
          exp.enable_right_out = 1'b0;
          exp.heat_off_right   = 1'b1;
        end
        if (!fuse_ignored) begin
          if (!st_fl) begin
            exp.enable_left_out = 1'b0;
            exp.heat_off_left   = 1'b1;
          end
          if (!st_fr) begin
            exp.enable_right_out = 1'b0;
            exp.heat_off_right   = 1'b1;
          end
        end
        // The protector check needs both the settled and the raw presence level.
        if (!exp.stop && need_l && st_pl && it.raw_pins[0] && it.adc_left_valid &&
            it.adc_left >= adc_thresh) begin
          exp.stop       = 1'b1;
          exp.stop_cause = hssi_pkg::REASON_LEFT;
        end
        if (!exp.stop && need_r && st_pr && it.raw_pins[1] && it.adc_right_valid &&
            it.adc_right >= adc_thresh) begin
          exp.stop       = 1'b1;
          exp.stop_cause = hssi_pkg::REASON_RIGHT;
        end
      end else begin
        req = (it.blow_req_left ? hssi_pkg::SIDE_LEFT : 2'b00) |
              (it.blow_req_right ? hssi_pkg::SIDE_RIGHT : 2'b00);
        if (req != 2'b00) begin
          blow_act   = blow_act | req;
          pulse_left = pulse_len;
        end else if (blow_act != 2'b00 && pulse_left != '0) begin
          pulse_left = pulse_left - 16'd1;
        end
        if (blow_act != 2'b00 && pulse_left == '0) blow_act = 2'b00;
      end
      exp.present_left     = st_pl;
      exp.present_right    = st_pr;
      exp.fuse_left_ok     = st_fl;
      exp.fuse_right_ok    = st_fr;
      exp.blow_drive_left  = |(blow_act & hssi_pkg::SIDE_LEFT);
      exp.blow_drive_right = |(blow_act & hssi_pkg::SIDE_RIGHT);
      awaited_results.push_back(exp);
    endfunction

    function void flag(string what, hssi_pkg::out_item_t exp, hssi_pkg::out_item_t got);
      mismatches++;
      if (mismatches <= 10) $display("%s: expected %h, got %h", what, exp, got);
    endfunction

    function void check_result(hssi_pkg::out_item_t got);
      hssi_pkg::out_item_t exp;
      if (awaited_results.size() == 0) begin
        flag("result with no item waiting", '0, got);
        return;
      end
      exp = awaited_results.pop_front();
      if (got.present_left !== exp.present_left || got.present_right !== exp.present_right ||
          got.fuse_left_ok !== exp.fuse_left_ok || got.fuse_right_ok !== exp.fuse_right_ok ||
          got.stop !== exp.stop || got.stop_cause !== exp.stop_cause ||
          got.enable_left_out !== exp.enable_left_out ||
          got.enable_right_out !== exp.enable_right_out ||
          got.heat_off_left !== exp.heat_off_left || got.heat_off_right !== exp.heat_off_right ||
          got.blow_drive_left !== exp.blow_drive_left ||
          got.blow_drive_right !== exp.blow_drive_right)
        flag("result differs", exp, got);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                          cfg_we;
  logic [hssi_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [hssi_pkg::CfgDataW-1:0] cfg_data;

  hssi_in_if  in_if ();
  hssi_out_if out_if ();

  heater_shield_safety_interlock_core uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  interlock_checker board = new();

  int       burst_left = 0;
  int       hold_left  = 0;
  logic [3:0] hold_pins = 4'hF;
  int       rx_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver alternates between open stretches, solid stalls and random stalls.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      case (rx_mode)
        RX_OPEN: rx_left = $urandom_range(1, 40);
        RX_HOLD: rx_left = $urandom_range(1, 8);
        default: rx_left = $urandom_range(1, 30);
      endcase
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: out_if.ready <= 1'b1;
      RX_HOLD: out_if.ready <= 1'b0;
      default: out_if.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) board.check_result(out_if.data);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  function automatic hssi_pkg::in_item_t make_item(logic kind, logic [3:0] pins, logic run,
                                         logic en_l, logic en_r,
                                         logic [hssi_pkg::AdcW-1:0] adc_l, logic val_l,
                                         logic [hssi_pkg::AdcW-1:0] adc_r, logic val_r,
                                         logic bl, logic br);
    hssi_pkg::in_item_t it;
    it.kind            = kind;
    it.raw_pins        = pins;
    it.running         = run;
    it.enable_left     = en_l;
    it.enable_right    = en_r;
    it.adc_left        = adc_l;
    it.adc_left_valid  = val_l;
    it.adc_right       = adc_r;
    it.adc_right_valid = val_r;
    it.blow_req_left   = bl;
    it.blow_req_right  = br;
    return it;
  endfunction

  // ADC values cluster around the threshold so both sides of the compare are hit.
  function automatic logic [hssi_pkg::AdcW-1:0] pick_adc(logic [hssi_pkg::AdcW-1:0] thr);
    case ($urandom_range(0, 5))
      0: return 12'($urandom_range(0, 4095));
      1: return thr;
      2: return thr - 12'd1;
      3: return thr + 12'd1;
      4: return hssi_pkg::ADC_FULL;
      default: return '0;
    endcase
  endfunction

  // Pins are held for a run of samples so that the debouncers settle, with the
  // odd single-sample glitch thrown in.
  function automatic hssi_pkg::in_item_t next_random_item();
    hssi_pkg::in_item_t it;
    it.kind = ($urandom_range(0, 9) < 3) ? hssi_pkg::KIND_TICK : hssi_pkg::KIND_SAMPLE;
    if (hold_left == 0) begin
      hold_pins = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
      hold_left = $urandom_range(1, 12);
    end
    hold_left--;
    it.raw_pins = hold_pins;
    if ($urandom_range(0, 9) == 0) it.raw_pins = it.raw_pins ^ (4'b0001 << $urandom_range(0, 3));
    it.running         = ($urandom_range(0, 3) != 0);
    it.enable_left     = ($urandom_range(0, 3) != 0);
    it.enable_right    = ($urandom_range(0, 3) != 0);
    it.adc_left        = pick_adc(board.adc_thresh);
    it.adc_left_valid  = ($urandom_range(0, 3) != 0);
    it.adc_right       = pick_adc(board.adc_thresh);
    it.adc_right_valid = ($urandom_range(0, 3) != 0);
    if (it.kind == hssi_pkg::KIND_TICK) begin
      it.blow_req_left  = ($urandom_range(0, 7) == 0);
      it.blow_req_right = ($urandom_range(0, 7) == 0);
    end else begin
      it.blow_req_left  = 1'($urandom_range(0, 1));
      it.blow_req_right = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input hssi_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    board.take_item(it);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [hssi_pkg::CfgIdxW-1:0] idx,
                         input logic [hssi_pkg::CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [hssi_pkg::DbW-1:0] pd,
                           input logic [hssi_pkg::DbW-1:0] fd,
                           input logic [hssi_pkg::AdcW-1:0] th,
                           input logic [hssi_pkg::PulseW-1:0] pt,
                           input logic ig);
    put_reg(hssi_pkg::REG_PRESENT_DB, 16'(pd));
    put_reg(hssi_pkg::REG_FUSE_DB, 16'(fd));
    put_reg(hssi_pkg::REG_ADC_THRESH, 16'(th));
    put_reg(hssi_pkg::REG_PULSE_TICKS, pt);
    put_reg(hssi_pkg::REG_IGNORE_FUSE, 16'(ig));
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    hssi_pkg::in_item_t it;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed items at the reset settings.
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                        12'd4087, 1'b1, 12'd0, 1'b1, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                        12'd4086, 1'b1, 12'd4095, 1'b1, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                        12'd4095, 1'b0, 12'd4095, 1'b0, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b0, 1'b1, 1'b1,
                        12'd4095, 1'b1, 12'd4095, 1'b1, 1'b0, 1'b0));
    // Raw left presence low keeps the left protector out, so the right one wins.
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hE, 1'b1, 1'b1, 1'b1,
                        12'd4095, 1'b1, 12'd4095, 1'b1, 1'b0, 1'b0));
    repeat (3) send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'h0, 1'b1, 1'b1, 1'b1,
                                   12'd0, 1'b1, 12'd0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                        12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'h0, 1'b1, 1'b1, 1'b1,
                        12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0));
    repeat (3) send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                                   12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0));
    repeat (3) send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'h3, 1'b1, 1'b1, 1'b1,
                                   12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0));
    repeat (3) send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                                   12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_TICK, 4'h0, 1'b0, 1'b0, 1'b0,
                        12'd0, 1'b0, 12'd0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(hssi_pkg::KIND_TICK, 4'h0, 1'b0, 1'b0, 1'b0,
                        12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_TICK, 4'h0, 1'b0, 1'b1, 1'b0,
                        12'd0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b1));
    send_item(make_item(hssi_pkg::KIND_TICK, 4'hF, 1'b1, 1'b1, 1'b1,
                        12'd4095, 1'b1, 12'd4095, 1'b1, 1'b1, 1'b1));

    // A zero debounce count takes a new level at once; a zero pulse never shows.
    quiesce();
    configure(8'd0, 8'd0, 12'd0, 16'd0, 1'b1);
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'h0, 1'b1, 1'b1, 1'b1,
                        12'd0, 1'b1, 12'd0, 1'b1, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_SAMPLE, 4'hF, 1'b1, 1'b1, 1'b1,
                        12'd0, 1'b1, 12'd0, 1'b1, 1'b0, 1'b0));
    send_item(make_item(hssi_pkg::KIND_TICK, 4'h0, 1'b0, 1'b0, 1'b0,
                        12'd0, 1'b0, 12'd0, 1'b0, 1'b1, 1'b1));

    for (int phase = 0; phase < 8; phase++) begin
      quiesce();
      case (phase)
        0: configure(hssi_pkg::RST_PRESENT_DB, hssi_pkg::RST_FUSE_DB,
                     hssi_pkg::RST_ADC_THRESH, hssi_pkg::RST_PULSE_TICKS, 1'b0);
        1: configure(8'd1, 8'd1, 12'd0, 16'd0, 1'b1);
        2: configure(8'd255, 8'd255, 12'd4095, 16'hFFFF, 1'b0);
        3: configure(8'd0, 8'd0, 12'd2048, 16'd1, 1'b0);
        4: configure(8'd2, 8'd5, 12'd4000, 16'd3, 1'b1);
        5: configure(8'd4, 8'd2, 12'd1, 16'd7, 1'b0);
        6: configure(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                     12'($urandom_range(0, 4095)), 16'($urandom_range(0, 20)),
                     1'($urandom_range(0, 1)));
        default: configure(hssi_pkg::RST_PRESENT_DB, hssi_pkg::RST_FUSE_DB,
                           hssi_pkg::RST_ADC_THRESH, hssi_pkg::RST_PULSE_TICKS, 1'b0);
      endcase
      repeat (PhaseItems) begin
        it = next_random_item();
        send_item(it);
      end
    end

    quiesce();
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
